// ===== hdl/tsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tsfd_pkg
// Shared widths, register indexes, reset values and helpers for the
// tempo-synced stereo feedback delay.
// ----------------------------------------------------------------------------
package tsfd_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 16;
    localparam int QTR_W      = 5;
    localparam int BPM_W      = 10;
    localparam int RATE_W     = 18;
    localparam int PROD_W     = QTR_W + RATE_W;
    // quarters * rate * 15 always fits in this many bits
    localparam int NUM_W      = PROD_W + 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam int DEF_MAX_FRAMES = 131072;

    localparam logic [QTR_W-1:0]  RST_QUARTERS = QTR_W'(3);
    localparam logic [BPM_W-1:0]  RST_BPM      = BPM_W'(120);
    localparam logic [RATE_W-1:0] RST_RATE     = RATE_W'(48000);
    localparam logic [GAIN_W-1:0] RST_FEEDBACK = GAIN_W'(24576);
    localparam logic [GAIN_W-1:0] RST_DRY      = GAIN_W'(24576);
    localparam logic [GAIN_W-1:0] RST_WET      = GAIN_W'(13107);

    // Unclamped delay length of the reset configuration.
    localparam int RST_LEN_RAW = (3 * 48000 * 15) / 120;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_QUARTERS = 3'd0,
        REG_TEMPO_BPM      = 3'd1,
        REG_SAMPLE_RATE    = 3'd2,
        REG_FEEDBACK_GAIN  = 3'd3,
        REG_DRY_GAIN       = 3'd4,
        REG_WET_GAIN       = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [GAIN_W-1:0] feedback;
        logic [GAIN_W-1:0] dry;
        logic [GAIN_W-1:0] wet;
    } t_gains;

    // Saturate a 27-bit signed value to the Q1.23 sample range.
    function automatic logic [SAMPLE_W-1:0] sat24(input logic signed [SAMPLE_W+2:0] v);
        logic [SAMPLE_W-1:0] res;
        if (v > (SAMPLE_W+3)'(signed'(8388607))) begin
            res = 24'h7FFFFF;
        end else if (v < -(SAMPLE_W+3)'(signed'(8388608))) begin
            res = 24'h800000;
        end else begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/tsfd_div.sv =====
// ----------------------------------------------------------------------------
// tsfd_div
// Restoring divider, one quotient bit per cycle, giving quotient and
// remainder.
// ----------------------------------------------------------------------------
module tsfd_div import tsfd_pkg::*; #(
    parameter int N = NUM_W,
    parameter int D = BPM_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_num,
    input  logic [D-1:0] i_den,
    output logic         o_done,
    output logic [N-1:0] o_quo,
    output logic [D-1:0] o_rem
);

    localparam int CW = $clog2(N);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [N-1:0]  r_quo;
    logic [D-1:0]  r_rem;
    logic [D-1:0]  r_den;
    logic [D:0]    trial;
    logic          ge;

    assign trial = {r_rem, r_quo[N-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(N - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(N - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[N-2:0], ge};
            r_rem <= ge ? D'(trial - {1'b0, r_den}) : trial[D-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/tsfd_len.sv =====
// ----------------------------------------------------------------------------
// tsfd_len
// Delay length sequencer: multiplies out quarters * rate * 15, divides by
// the tempo, clamps, then reduces the write position modulo the new length.
// ----------------------------------------------------------------------------
module tsfd_len import tsfd_pkg::*; #(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [QTR_W-1:0]                   i_quarters,
    input  logic [BPM_W-1:0]                   i_bpm,
    input  logic [RATE_W-1:0]                  i_rate,
    input  logic [$clog2(MAX_FRAMES)-1:0]      i_pos,
    output logic                               o_busy,
    output logic                               o_load,
    output logic [$clog2(MAX_FRAMES+1)-1:0]    o_len,
    output logic [$clog2(MAX_FRAMES)-1:0]      o_pos
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int LW = $clog2(MAX_FRAMES + 1);
    localparam int DW = (BPM_W > LW) ? BPM_W : LW;

    typedef enum logic [3:0] {
        LS_IDLE = 4'b0001,
        LS_MUL  = 4'b0010,
        LS_DIV  = 4'b0100,
        LS_MOD  = 4'b1000
    } t_len_state;

    t_len_state        r_state, n_state;
    logic [PROD_W-1:0] r_prod;
    logic [LW-1:0]     r_len;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num, div_quo;
    logic [DW-1:0]     div_den, div_rem;
    logic [LW-1:0]     clamped;

    tsfd_div #(.N(NUM_W), .D(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // Zero tempo and over-long results go to the full store; zero goes to one.
    always_comb begin
        if (i_bpm == '0 || div_quo > NUM_W'(MAX_FRAMES)) begin
            clamped = LW'(MAX_FRAMES);
        end else if (div_quo == '0) begin
            clamped = LW'(1);
        end else begin
            clamped = div_quo[LW-1:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            LS_IDLE: begin
                if (i_start) begin
                    n_state = LS_MUL;
                end
            end
            LS_MUL: begin
                div_start = 1'b1;
                div_num   = (NUM_W'(r_prod) << 4) - NUM_W'(r_prod);
                div_den   = DW'(i_bpm);
                n_state   = LS_DIV;
            end
            LS_DIV: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_num   = NUM_W'(i_pos);
                    div_den   = DW'(clamped);
                    n_state   = LS_MOD;
                end
            end
            LS_MOD: begin
                if (div_done) begin
                    n_state = LS_IDLE;
                end
            end
            default: begin
                n_state = LS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == LS_IDLE && i_start) begin
            r_prod <= PROD_W'(i_quarters) * PROD_W'(i_rate);
        end
        if (r_state == LS_DIV && div_done) begin
            r_len <= clamped;
        end
    end

    assign o_busy = (r_state != LS_IDLE);
    assign o_load = (r_state == LS_MOD) && div_done;
    assign o_len  = r_len;
    assign o_pos  = AW'(div_rem);

endmodule

// ===== hdl/tsfd_core.sv =====
// ----------------------------------------------------------------------------
// tsfd_core
// Delay store and its read-modify-write pipeline: read at the write
// position, multiply by the gains, then write back and mix.
// ----------------------------------------------------------------------------
module tsfd_core import tsfd_pkg::*; #(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int RESET_LEN  = RST_LEN_RAW
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [SAMPLE_W-1:0]                i_in_left,
    input  logic [SAMPLE_W-1:0]                i_in_right,
    input  t_gains                             i_gains,
    input  logic                               i_load,
    input  logic [$clog2(MAX_FRAMES+1)-1:0]    i_len,
    input  logic [$clog2(MAX_FRAMES)-1:0]      i_pos,
    output logic [$clog2(MAX_FRAMES)-1:0]      o_pos,
    output logic                               o_s1_busy,
    output logic                               o_push,
    output logic [SAMPLE_W-1:0]                o_out_left,
    output logic [SAMPLE_W-1:0]                o_out_right
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int LW = $clog2(MAX_FRAMES + 1);
    localparam int PW = SAMPLE_W + GAIN_W + 1;
    localparam int SW = SAMPLE_W + 3;

    logic [2*SAMPLE_W-1:0] r_mem [MAX_FRAMES];
    logic [2*SAMPLE_W-1:0] r_rd_data;

    logic [AW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_len;
    // Entries below this mark have been written since reset.
    logic [LW-1:0] r_hw, n_hw;

    logic                 r_s1_valid, r_s1_hit;
    logic [AW-1:0]        r_s1_addr;
    logic [SAMPLE_W-1:0]  r_s1_x_l, r_s1_x_r;

    logic                 r_s2_valid;
    logic [AW-1:0]        r_s2_addr;
    logic [SAMPLE_W-1:0]  r_s2_x_l, r_s2_x_r;
    logic signed [PW-1:0] r_p_fb_l, r_p_fb_r, r_p_dry_l, r_p_dry_r, r_p_wet_l, r_p_wet_r;

    logic                  r_lw_valid;
    logic [AW-1:0]         r_lw_addr;
    logic [2*SAMPLE_W-1:0] r_lw_data;

    logic signed [SAMPLE_W-1:0] d_l, d_r;
    logic signed [GAIN_W:0]     g_fb, g_dry, g_wet;
    logic [2*SAMPLE_W-1:0]      s1_word;
    logic signed [SW-1:0]       st_sum_l, st_sum_r, mix_l, mix_r;
    logic signed [PW:0]         mix_full_l, mix_full_r;
    logic [SAMPLE_W-1:0]        st_l, st_r;

    // Position advance or load, and written-region mark.
    always_comb begin
        n_pos = r_pos;
        n_hw  = r_hw;
        if (i_accept) begin
            n_pos = (LW'(r_pos) + LW'(1) >= r_len) ? '0 : r_pos + AW'(1);
            if (LW'(r_pos) == r_hw) begin
                n_hw = r_hw + LW'(1);
            end
        end else if (i_load) begin
            n_pos = i_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_len      <= LW'(RESET_LEN);
            r_hw       <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_lw_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_hw       <= n_hw;
            r_s1_valid <= i_accept;
            r_s2_valid <= r_s1_valid;
            if (i_load) begin
                r_len <= i_len;
            end
            if (r_s2_valid) begin
                r_lw_valid <= 1'b1;
            end
        end
    end

    // Store: read every cycle at the current position, write from stage two.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_mem[r_s2_addr] <= {st_r, st_l};
        end
    end

    // Stage one: pick the delayed word, then form the six products.
    always_comb begin
        if (r_lw_valid && r_lw_addr == r_s1_addr) begin
            s1_word = r_lw_data;
        end else if (r_s1_hit) begin
            s1_word = r_rd_data;
        end else begin
            s1_word = '0;
        end
    end

    assign d_l   = s1_word[SAMPLE_W-1:0];
    assign d_r   = s1_word[2*SAMPLE_W-1:SAMPLE_W];
    assign g_fb  = {1'b0, i_gains.feedback};
    assign g_dry = {1'b0, i_gains.dry};
    assign g_wet = {1'b0, i_gains.wet};

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_addr <= r_pos;
            r_s1_hit  <= LW'(r_pos) < r_hw;
            r_s1_x_l  <= i_in_left;
            r_s1_x_r  <= i_in_right;
        end
        r_s2_addr <= r_s1_addr;
        r_s2_x_l  <= r_s1_x_l;
        r_s2_x_r  <= r_s1_x_r;
        r_p_fb_l  <= d_l * g_fb;
        r_p_fb_r  <= d_r * g_fb;
        r_p_dry_l <= $signed(r_s1_x_l) * g_dry;
        r_p_dry_r <= $signed(r_s1_x_r) * g_dry;
        r_p_wet_l <= d_l * g_wet;
        r_p_wet_r <= d_r * g_wet;
        if (r_s2_valid) begin
            r_lw_addr <= r_s2_addr;
            r_lw_data <= {st_r, st_l};
        end
    end

    // Stage two: floor by the arithmetic shift, then saturate.
    assign st_sum_l   = SW'($signed(r_s2_x_l)) + SW'(r_p_fb_l >>> 15);
    assign st_sum_r   = SW'($signed(r_s2_x_r)) + SW'(r_p_fb_r >>> 15);
    assign mix_full_l = (PW+1)'(r_p_dry_l) + (PW+1)'(r_p_wet_l);
    assign mix_full_r = (PW+1)'(r_p_dry_r) + (PW+1)'(r_p_wet_r);
    assign mix_l      = mix_full_l[PW:15];
    assign mix_r      = mix_full_r[PW:15];
    assign st_l       = sat24(st_sum_l);
    assign st_r       = sat24(st_sum_r);

    assign o_pos       = r_pos;
    assign o_s1_busy   = r_s1_valid;
    assign o_push      = r_s2_valid;
    assign o_out_left  = sat24(mix_l);
    assign o_out_right = sat24(mix_r);

    a_pos_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_pos) < r_len)
        else $error("write position at or past the delay length");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_valid && r_s2_valid))
        else $error("two words in the store pipeline at once");

    a_mark_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= LW'(MAX_FRAMES))
        else $error("written-region mark beyond the store");

endmodule

// ===== hdl/tempo_synced_stereo_feedback_delay.sv =====
// ----------------------------------------------------------------------------
// tempo_synced_stereo_feedback_delay
// Stereo feedback delay whose length follows the tempo, the sample rate and
// a delay setting in quarter beats.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+------------------------------
//  in       | sink      | i_in_valid / o_in_stall | i_in_left, i_in_right
//  out      | source    | o_out_valid / i_out_stall | o_out_left, o_out_right
//  cfg      | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  A word passes through the store in steps: its entry is read into a register,
//  its products are registered, and then it is written back and mixed. A new
//  word is not taken while the last is in stage one, set by the single
//  read and write of the store. A write to a known register starts the length
//  unit (a multiply, a bit-serial divide, then the position modulo); the in
//  and cfg ports stall meanwhile. Reset is synchronous and needs no clearing
//  pass: the store's reset value of zero is served by a mark of how far it has
//  been written. An output stall lets at most two words pile up; input then
//  stalls.
module tempo_synced_stereo_feedback_delay import tsfd_pkg::*; #(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_in_left,
    input  logic [SAMPLE_W-1:0]   i_in_right,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SAMPLE_W-1:0]   o_out_left,
    output logic [SAMPLE_W-1:0]   o_out_right,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW        = $clog2(MAX_FRAMES);
    localparam int LW        = $clog2(MAX_FRAMES + 1);
    localparam int RESET_LEN = (RST_LEN_RAW > MAX_FRAMES) ? MAX_FRAMES : RST_LEN_RAW;

    // Configuration registers.
    logic [QTR_W-1:0]  r_quarters;
    logic [BPM_W-1:0]  r_bpm;
    logic [RATE_W-1:0] r_rate;
    t_gains            r_gains;
    logic              r_len_start;

    // Words accepted and not yet delivered, and words held at the output.
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] r_occ, n_occ;
    logic [SAMPLE_W-1:0] r_head_l, r_head_r, r_skid_l, r_skid_r;

    logic          cfg_wr, cfg_known, in_acc, out_pop;
    logic          len_busy, len_load;
    logic [LW-1:0] len_value;
    logic [AW-1:0] len_pos, core_pos;
    logic          s1_busy, push;
    logic [SAMPLE_W-1:0] res_l, res_r;

    assign cfg_wr  = i_cfg_valid && o_cfg_ready;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_pop = o_out_valid && !i_out_stall;

    // Indexes past the last register are ignored and leave the length alone.
    assign cfg_known = (i_cfg_index <= REG_WET_GAIN);

    // Only one write at a time reaches the length unit.
    assign o_cfg_ready = !len_busy && !r_len_start;

    // The store is read-modify-write, so no word enters while the last is in
    // stage one; the word count keeps the two-entry output buffer from overflowing.
    assign o_in_stall = len_busy || r_len_start || s1_busy || (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quarters       <= RST_QUARTERS;
            r_bpm            <= RST_BPM;
            r_rate           <= RST_RATE;
            r_gains.feedback <= RST_FEEDBACK;
            r_gains.dry      <= RST_DRY;
            r_gains.wet      <= RST_WET;
            r_len_start      <= 1'b0;
        end else begin
            r_len_start <= cfg_wr && cfg_known;
            if (cfg_wr) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_DELAY_QUARTERS: r_quarters       <= i_cfg_data[QTR_W-1:0];
                    REG_TEMPO_BPM:      r_bpm            <= i_cfg_data[BPM_W-1:0];
                    REG_SAMPLE_RATE:    r_rate           <= i_cfg_data[RATE_W-1:0];
                    REG_FEEDBACK_GAIN:  r_gains.feedback <= i_cfg_data[GAIN_W-1:0];
                    REG_DRY_GAIN:       r_gains.dry      <= i_cfg_data[GAIN_W-1:0];
                    REG_WET_GAIN:       r_gains.wet      <= i_cfg_data[GAIN_W-1:0];
                    default: begin
                        // Unknown indexes leave every register alone.
                    end
                endcase
            end
        end
    end

    tsfd_len #(.MAX_FRAMES(MAX_FRAMES)) u_len (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_len_start),
        .i_quarters (r_quarters),
        .i_bpm      (r_bpm),
        .i_rate     (r_rate),
        .i_pos      (core_pos),
        .o_busy     (len_busy),
        .o_load     (len_load),
        .o_len      (len_value),
        .o_pos      (len_pos)
    );

    tsfd_core #(.MAX_FRAMES(MAX_FRAMES), .RESET_LEN(RESET_LEN)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_acc),
        .i_in_left   (i_in_left),
        .i_in_right  (i_in_right),
        .i_gains     (r_gains),
        .i_load      (len_load),
        .i_len       (len_value),
        .i_pos       (len_pos),
        .o_pos       (core_pos),
        .o_s1_busy   (s1_busy),
        .o_push      (push),
        .o_out_left  (res_l),
        .o_out_right (res_r)
    );

    // Output buffer: the head drives the port, the skid entry catches a word
    // that finishes while the head is stalled.
    always_comb begin
        n_cnt = r_cnt;
        if (in_acc && !out_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!in_acc && out_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
        n_occ = r_occ;
        if (push && !out_pop) begin
            n_occ = r_occ + 2'd1;
        end else if (!push && out_pop) begin
            n_occ = r_occ - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_occ <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_pop) begin
            if (r_occ == 2'd2) begin
                r_head_l <= r_skid_l;
                r_head_r <= r_skid_r;
            end else begin
                r_head_l <= res_l;
                r_head_r <= res_r;
            end
            if (push) begin
                r_skid_l <= res_l;
                r_skid_r <= res_r;
            end
        end else if (push) begin
            if (r_occ == 2'd0) begin
                r_head_l <= res_l;
                r_head_r <= res_r;
            end else begin
                r_skid_l <= res_l;
                r_skid_r <= res_r;
            end
        end
    end

    assign o_out_valid = (r_occ != 2'd0);
    assign o_out_left  = r_head_l;
    assign o_out_right = r_head_r;

    a_buffer_within_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= r_cnt)
        else $error("output buffer holds more words than are outstanding");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("more than two words outstanding");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == 2'd2) |-> !push)
        else $error("result arrived with the output buffer full");

endmodule
